// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file dtw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: label");

// implication checked during reset too
`define ASSERT_ALWAYS(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |-> (b)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/dtw_pkg.sv =====
// ---------------------------------------------------------------------------
// dtw_pkg
// Types and constants of the work-based difficulty target block.
// ---------------------------------------------------------------------------
package dtw_pkg;

    localparam int WORK_W   = 256;
    localparam int LIMB_W   = 64;
    localparam int TIME_W   = 32;
    localparam int SPACE_W  = 16;
    localparam int SPAN_W   = 25;   // 288 * 65535 fits in 25 bits
    localparam int LO_W     = 23;   // 72 * 65535 fits in 23 bits
    localparam int SPAN_LOW_MULT  = 72;
    localparam int SPAN_HIGH_MULT = 288;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [2:0] REG_SPACING = 3'd0;
    localparam logic [2:0] REG_LIMIT0  = 3'd1;
    localparam logic [2:0] REG_LIMIT1  = 3'd2;
    localparam logic [2:0] REG_LIMIT2  = 3'd3;
    localparam logic [2:0] REG_LIMIT3  = 3'd4;

    localparam logic [SPACE_W-1:0] SPACING_RESET = 16'd600;

    typedef struct packed {
        logic [LIMB_W-1:0] first_work_w0;
        logic [LIMB_W-1:0] first_work_w1;
        logic [LIMB_W-1:0] first_work_w2;
        logic [LIMB_W-1:0] first_work_w3;
        logic [LIMB_W-1:0] last_work_w0;
        logic [LIMB_W-1:0] last_work_w1;
        logic [LIMB_W-1:0] last_work_w2;
        logic [LIMB_W-1:0] last_work_w3;
        logic [TIME_W-1:0] first_time;
        logic [TIME_W-1:0] last_time;
    } t_in_word;

    typedef struct packed {
        logic [LIMB_W-1:0] target_w0;
        logic [LIMB_W-1:0] target_w1;
        logic [LIMB_W-1:0] target_w2;
        logic [LIMB_W-1:0] target_w3;
        logic              was_limited;
        logic              zero_work;
    } t_out_word;

endpackage

// ===== rtl/dtw_if.sv =====
// ---------------------------------------------------------------------------
// dtw_in_if / dtw_out_if
// Valid/ready channels carrying input and result words.
// ---------------------------------------------------------------------------
interface dtw_in_if;
    import dtw_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtw_out_if;
    import dtw_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/difficulty_target_from_work_unit.sv =====
// ---------------------------------------------------------------------------
// difficulty_target_from_work_unit
// Next target from chain work and timestamps, fully pipelined.
// ---------------------------------------------------------------------------
// channel   dir   handshake          word
// s_in      in    valid/ready        two 256-bit work sums, two timestamps
// m_out     out   valid/ready        256-bit target, limited, zero flags
// apb       in    psel/penable/pwr   spacing and 256-bit limit
//
// One word per cycle unless stalled. Stages: difference/span, partial products,
// sum/clamp, 256 steps of the divide by the time span, negate, 256 steps of
// the 256-bit divide, output register. The restoring divide steps set the depth.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// A stall of m_out parks one word in a skid register and then freezes the pipe.
// ---------------------------------------------------------------------------
module difficulty_target_from_work_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dtw_in_if.sink                     s_in,
    dtw_out_if.source                  m_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dtw_pkg::APB_AW-1:0] paddr,
    input  logic [dtw_pkg::APB_DW-1:0] pwdata,
    output logic [dtw_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import dtw_pkg::*;

    localparam int STEPS = WORK_W;

    // configuration
    logic [SPACE_W-1:0] r_spacing;
    logic [LIMB_W-1:0]  r_limit [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
            for (int i = 0; i < 4; i++) r_limit[i] <= '1;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_SPACING: r_spacing  <= pwdata[SPACE_W-1:0];
                REG_LIMIT0:  r_limit[0] <= pwdata;
                REG_LIMIT1:  r_limit[1] <= pwdata;
                REG_LIMIT2:  r_limit[2] <= pwdata;
                REG_LIMIT3:  r_limit[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SPACING: prdata = {{(APB_DW-SPACE_W){1'b0}}, r_spacing};
            REG_LIMIT0:  prdata = r_limit[0];
            REG_LIMIT1:  prdata = r_limit[1];
            REG_LIMIT2:  prdata = r_limit[2];
            REG_LIMIT3:  prdata = r_limit[3];
            default:     prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // pipe advances while the skid register is empty
    logic r_skid_v;
    logic en;
    assign en = !r_skid_v;
    assign s_in.ready = en;

    // stage A: work difference and time span
    logic              r_a_v;
    logic [WORK_W-1:0] r_a_diff;
    logic signed [TIME_W:0] r_a_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en) r_a_v <= s_in.valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_diff <= {s_in.data.last_work_w3, s_in.data.last_work_w2,
                         s_in.data.last_work_w1, s_in.data.last_work_w0}
                      - {s_in.data.first_work_w3, s_in.data.first_work_w2,
                         s_in.data.first_work_w1, s_in.data.first_work_w0};
            r_a_span <= $signed({1'b0, s_in.data.last_time})
                      - $signed({1'b0, s_in.data.first_time});
        end
    end

    // stage B: 32x16 partial products and clamp bounds
    logic              r_b_v;
    logic [47:0]       r_b_pp [8];
    logic [LO_W-1:0]   r_b_lo;
    logic [SPAN_W-1:0] r_b_hi;
    logic signed [TIME_W:0] r_b_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en) r_b_v <= r_a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 8; i++)
                r_b_pp[i] <= 48'(r_a_diff[32*i +: 32]) * 48'(r_spacing);
            r_b_lo   <= LO_W'(r_spacing) * LO_W'(SPAN_LOW_MULT);
            r_b_hi   <= SPAN_W'(r_spacing) * SPAN_W'(SPAN_HIGH_MULT);
            r_b_span <= r_a_span;
        end
    end

    // stage C: product sum (low 256 bits) and clamped divisor
    logic              r_c_v;
    logic [WORK_W-1:0] r_c_prod;
    logic [SPAN_W-1:0] r_c_d;
    logic [WORK_W-1:0] pp_even, pp_odd;
    logic [SPAN_W-1:0] span_cl;

    assign pp_even = {16'b0, r_b_pp[6], 16'b0, r_b_pp[4],
                      16'b0, r_b_pp[2], 16'b0, r_b_pp[0]};
    assign pp_odd  = {r_b_pp[7][31:0], 16'b0, r_b_pp[5], 16'b0, r_b_pp[3],
                      16'b0, r_b_pp[1], 32'b0};

    always_comb begin
        if (r_b_span > $signed({8'b0, r_b_hi}))
            span_cl = r_b_hi;
        else if (r_b_span < $signed({10'b0, r_b_lo}))
            span_cl = SPAN_W'(r_b_lo);
        else
            span_cl = r_b_span[SPAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en) r_c_v <= r_b_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            // zero spacing: zero dividend over one gives zero work
            if (span_cl == '0) begin
                r_c_prod <= '0;
                r_c_d    <= SPAN_W'(1);
            end else begin
                r_c_prod <= pp_even + pp_odd;
                r_c_d    <= span_cl;
            end
        end
    end

    // divide by span: one quotient bit per stage
    logic              r_q1_v [STEPS];
    logic [WORK_W-1:0] r_q1_a [STEPS];
    logic [SPAN_W-1:0] r_q1_r [STEPS];
    logic [SPAN_W-1:0] r_q1_d [STEPS];
    logic [WORK_W-1:0] n_q1_a [STEPS];
    logic [SPAN_W-1:0] n_q1_r [STEPS];

    always_comb begin : div1_step
        logic [WORK_W-1:0] sa;
        logic [SPAN_W-1:0] sr, sd;
        logic [SPAN_W:0]   cur;
        logic              qb;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                sa = r_c_prod;  sr = '0;          sd = r_c_d;
            end else begin
                sa = r_q1_a[k-1]; sr = r_q1_r[k-1]; sd = r_q1_d[k-1];
            end
            cur = {sr, sa[WORK_W-1]};
            qb  = (cur >= {1'b0, sd});
            n_q1_r[k] = qb ? SPAN_W'(cur - {1'b0, sd}) : cur[SPAN_W-1:0];
            n_q1_a[k] = {sa[WORK_W-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) r_q1_v[k] <= 1'b0;
        end else if (en) begin
            r_q1_v[0] <= r_c_v;
            for (int k = 1; k < STEPS; k++) r_q1_v[k] <= r_q1_v[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_d[0] <= r_c_d;
            for (int k = 1; k < STEPS; k++) r_q1_d[k] <= r_q1_d[k-1];
            for (int k = 0; k < STEPS; k++) begin
                r_q1_a[k] <= n_q1_a[k];
                r_q1_r[k] <= n_q1_r[k];
            end
        end
    end

    // stage Z: zero test and 2^256 - W
    logic              r_z_v, r_z_zero;
    logic [WORK_W-1:0] r_z_neg, r_z_d;
    logic [WORK_W-1:0] w_work;
    assign w_work = r_q1_a[STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_z_v <= 1'b0;
        else if (en) r_z_v <= r_q1_v[STEPS-1];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z_zero <= (w_work == '0);
            r_z_neg  <= ~w_work + WORK_W'(1);
            r_z_d    <= (w_work == '0) ? WORK_W'(1) : w_work;
        end
    end

    // 256-bit restoring divide: one quotient bit per stage
    logic              r_q2_v [STEPS];
    logic              r_q2_z [STEPS];
    logic [WORK_W-1:0] r_q2_a [STEPS];
    logic [WORK_W-1:0] r_q2_r [STEPS];
    logic [WORK_W-1:0] r_q2_d [STEPS];
    logic [WORK_W-1:0] n_q2_a [STEPS];
    logic [WORK_W-1:0] n_q2_r [STEPS];

    always_comb begin : div2_step
        logic [WORK_W-1:0] sa, sr, sd;
        logic [WORK_W:0]   cur;
        logic              qb;
        for (int k = 0; k < STEPS; k++) begin
            if (k == 0) begin
                sa = r_z_neg;   sr = '0;          sd = r_z_d;
            end else begin
                sa = r_q2_a[k-1]; sr = r_q2_r[k-1]; sd = r_q2_d[k-1];
            end
            cur = {sr, sa[WORK_W-1]};
            qb  = (cur >= {1'b0, sd});
            n_q2_r[k] = qb ? WORK_W'(cur - {1'b0, sd}) : cur[WORK_W-1:0];
            n_q2_a[k] = {sa[WORK_W-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) r_q2_v[k] <= 1'b0;
        end else if (en) begin
            r_q2_v[0] <= r_z_v;
            for (int k = 1; k < STEPS; k++) r_q2_v[k] <= r_q2_v[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q2_d[0] <= r_z_d;
            r_q2_z[0] <= r_z_zero;
            for (int k = 1; k < STEPS; k++) begin
                r_q2_d[k] <= r_q2_d[k-1];
                r_q2_z[k] <= r_q2_z[k-1];
            end
            for (int k = 0; k < STEPS; k++) begin
                r_q2_a[k] <= n_q2_a[k];
                r_q2_r[k] <= n_q2_r[k];
            end
        end
    end

    // limit clamp, feeds the output register
    logic [WORK_W-1:0] lim, tgt;
    t_out_word res;
    assign lim = {r_limit[3], r_limit[2], r_limit[1], r_limit[0]};

    always_comb begin
        res = '0;
        tgt = r_q2_a[STEPS-1];
        if (r_q2_z[STEPS-1]) begin
            tgt = '0;
            res.zero_work = 1'b1;
        end else if (tgt > lim) begin
            tgt = lim;
            res.was_limited = 1'b1;
        end
        res.target_w0 = tgt[0*LIMB_W +: LIMB_W];
        res.target_w1 = tgt[1*LIMB_W +: LIMB_W];
        res.target_w2 = tgt[2*LIMB_W +: LIMB_W];
        res.target_w3 = tgt[3*LIMB_W +: LIMB_W];
    end

    // output register with skid
    logic      r_out_v;
    t_out_word r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (m_out.ready || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_q2_v[STEPS-1];
            end
        end else if (r_q2_v[STEPS-1] && en) begin
            r_skid_v <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (m_out.ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (en) begin
            r_skid <= res;
        end
    end

    assign m_out.valid = r_out_v;
    assign m_out.data  = r_out;

endmodule

// ===== rtl/dtw_checker.sv =====
// ---------------------------------------------------------------------------
// dtw_checker
// Port-level checks of the difficulty target block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input dtw_pkg::t_out_word i_out_data
);
    import dtw_pkg::*;

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // zero work gives a zero, unlimited target
    `ASSERT_IMPL(a_zero_target, i_clk, i_rst_n, i_out_valid && i_out_data.zero_work, !i_out_data.was_limited && i_out_data.target_w0 == '0 && i_out_data.target_w1 == '0 && i_out_data.target_w2 == '0 && i_out_data.target_w3 == '0)

    // right after reset the pipe is empty and takes words
    `ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) && i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind difficulty_target_from_work_unit dtw_checker u_dtw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (s_in.ready),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready),
    .i_out_data  (m_out.data)
);

// ===== tb/sv/dtw_target_checker.sv =====
// ---------------------------------------------------------------------------
// dtw_target_checker
// Snoops the register port and both channels, computes the next target for
// every accepted input word and compares it with the result words in order.
// ---------------------------------------------------------------------------
module dtw_target_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dtw_in_if                            in_ch,
    dtw_out_if                           out_ch,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [dtw_pkg::APB_AW-1:0]   i_paddr,
    input  logic [dtw_pkg::APB_DW-1:0]   i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dtw_pkg::*;

    logic [SPACE_W-1:0] spacing;
    logic [WORK_W-1:0]  limit;
    t_out_word          targets_due[$];

    function automatic t_out_word next_target(t_in_word w);
        logic [WORK_W-1:0] scaled;
        logic [WORK_W-1:0] tgt;
        logic [WORK_W:0]   num;
        longint            span;
        longint            lo;
        longint            hi;
        t_out_word         r;
        scaled = {w.last_work_w3, w.last_work_w2, w.last_work_w1, w.last_work_w0}
               - {w.first_work_w3, w.first_work_w2, w.first_work_w1, w.first_work_w0};
        scaled = scaled * {{(WORK_W-SPACE_W){1'b0}}, spacing};
        span = longint'(w.last_time) - longint'(w.first_time);
        lo   = SPAN_LOW_MULT * longint'(spacing);
        hi   = SPAN_HIGH_MULT * longint'(spacing);
        if (span > hi) span = hi;
        else if (span < lo) span = lo;
        if (span > 0) scaled = scaled / WORK_W'(span);
        else scaled = '0;
        r = '0;
        if (scaled == '0) begin
            r.zero_work = 1'b1;
            return r;
        end
        // (2^256 - W) / W, done one bit wider
        num = {1'b1, {WORK_W{1'b0}}} - {1'b0, scaled};
        tgt = WORK_W'(num / {1'b0, scaled});
        if (tgt > limit) begin
            tgt = limit;
            r.was_limited = 1'b1;
        end
        {r.target_w3, r.target_w2, r.target_w1, r.target_w0} = tgt;
        return r;
    endfunction

    assign o_pending = targets_due.size();

    always @(posedge i_clk) begin
        t_out_word e;
        t_out_word a;
        if (!i_rst_n) begin
            spacing <= SPACING_RESET;
            limit   <= '1;
            targets_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_SPACING: spacing <= i_pwdata[SPACE_W-1:0];
                    REG_LIMIT0:  limit[63:0]    <= i_pwdata;
                    REG_LIMIT1:  limit[127:64]  <= i_pwdata;
                    REG_LIMIT2:  limit[191:128] <= i_pwdata;
                    REG_LIMIT3:  limit[255:192] <= i_pwdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                targets_due.push_back(next_target(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.data;
                if (targets_due.size() == 0) begin
                    $error("result word with no target pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = targets_due.pop_front();
                    if (a !== e) o_fail_count <= o_fail_count + 1;
                    if (a.target_w0 !== e.target_w0)
                        $error("target_w0 exp %h got %h", e.target_w0, a.target_w0);
                    if (a.target_w1 !== e.target_w1)
                        $error("target_w1 exp %h got %h", e.target_w1, a.target_w1);
                    if (a.target_w2 !== e.target_w2)
                        $error("target_w2 exp %h got %h", e.target_w2, a.target_w2);
                    if (a.target_w3 !== e.target_w3)
                        $error("target_w3 exp %h got %h", e.target_w3, a.target_w3);
                    if (a.was_limited !== e.was_limited)
                        $error("was_limited exp %b got %b", e.was_limited, a.was_limited);
                    if (a.zero_work !== e.zero_work)
                        $error("zero_work exp %b got %b", e.zero_work, a.zero_work);
                end
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives the difficulty target unit through several spacing/limit settings
// with directed and random work/timestamp words under bursty input and a
// stalling output; the checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dtw_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 600;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    logic              hold_req;
    logic              hold_done;
    int                idle_cycles;
    logic [SPACE_W-1:0] cur_spacing;

    dtw_in_if  in_ch();
    dtw_out_if out_ch();

    difficulty_target_from_work_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dtw_target_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[difficulty_target_from_work_unit] ERROR");
            $finish;
        end
    end

    // receiver: random stall pattern, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                hold_done <= 1'b1;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'b0;
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SPACING) cur_spacing = value[SPACE_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] sp, logic [WORK_W-1:0] lim);
        reg_write(REG_SPACING, {48'd0, sp});
        reg_write(REG_LIMIT0, lim[63:0]);
        reg_write(REG_LIMIT1, lim[127:64]);
        reg_write(REG_LIMIT2, lim[191:128]);
        reg_write(REG_LIMIT3, lim[255:192]);
    endtask

    function automatic logic [WORK_W-1:0] rand_bits(int nbits);
        logic [WORK_W-1:0] r;
        for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
        if (nbits <= 0) return '0;
        if (nbits < WORK_W) r = r >> (WORK_W - nbits);
        return r;
    endfunction

    function automatic t_in_word make_word(logic [WORK_W-1:0] first, logic [WORK_W-1:0] diff,
                                           logic [31:0] t0, logic [31:0] t1);
        t_in_word w;
        logic [WORK_W-1:0] last;
        last = first + diff;
        {w.first_work_w3, w.first_work_w2, w.first_work_w1, w.first_work_w0} = first;
        {w.last_work_w3, w.last_work_w2, w.last_work_w1, w.last_work_w0} = last;
        w.first_time = t0;
        w.last_time  = t1;
        return w;
    endfunction

    function automatic t_in_word random_word();
        logic [31:0] t0;
        logic [31:0] t1;
        t0 = $urandom;
        case ($urandom_range(0, 9))
            0: t1 = $urandom;
            1: t1 = t0 - $urandom_range(0, 100000);
            default: t1 = t0 + $urandom_range(0, 400 * int'(cur_spacing));
        endcase
        return make_word(rand_bits($urandom_range(0, 256)), rand_bits($urandom_range(0, 256)),
                         t0, t1);
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_word(random_word());
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [WORK_W-1:0] ones;
        ones = '1;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        hold_req = 1'b0;
        cur_spacing = SPACING_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset settings
        send_word(make_word('0, '0, 32'd0, 32'd0));                  // zero work
        send_word(make_word(ones, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word('0, 256'd1, 32'd0, 32'd86400));          // tiny work
        send_word(make_word('0, ones, 32'd0, 32'd86400));            // huge work
        send_word(make_word(ones, 256'd1, 32'd0, 32'd100));          // wraps to 0
        send_word(make_word(256'd5, ones, 32'd1000, 32'd0));         // negative diff and time
        send_word(make_word('0, 256'd1 << 200, 32'd0, 32'hFFFF_FFFF));   // span capped high
        send_word(make_word('0, 256'd1 << 200, 32'hFFFF_FFFF, 32'd0));   // most negative span
        send_word(make_word('0, 256'd1 << 255, 32'd5, 32'd5));
        send_word(make_word('0, 256'd43200, 32'd0, 32'd43200));      // exactly 72 spacings
        send_word(make_word('0, 256'd172800, 32'd0, 32'd172800));    // exactly 288 spacings
        send_word(make_word('0, 256'd1 << 128, 32'd0, 32'd100000));
        send_word(make_word(rand_bits(256), rand_bits(256), 32'h8000_0000, 32'h7FFF_FFFF));
        in_ch.valid <= 1'b0;
        drain();

        // small limit, unit spacing
        set_config(16'd1, 256'h1_0000_0000);
        send_word(make_word('0, 256'd1, 32'd0, 32'd100));
        send_word(make_word('0, 256'd3, 32'd0, 32'd0));
        send_word(make_word('0, 256'd1 << 90, 32'd0, 32'd200));
        send_random(110);
        drain();

        // largest spacing, product overflows 256 bits
        set_config(16'hFFFF, ones);
        send_word(make_word('0, ones, 32'd0, 32'hFFFF_FFFF));
        send_random(50);
        hold_req <= 1'b1;
        send_random(60);
        drain();

        // zero spacing: every word is zero work
        set_config(16'd0, '0);
        send_random(15);
        drain();

        // zero limit, random spacing
        set_config(16'($urandom_range(2, 65534)), '0);
        send_random(100);
        drain();

        // mixed limit words
        set_config(16'd600, {64'd0, 64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_5555_5555, 64'd0});
        send_random(90);
        drain();

        set_config(16'($urandom_range(1, 65535)), rand_bits($urandom_range(1, 256)));
        send_random(110);
        drain();

        if (fail_count == 0) begin
            $display("[difficulty_target_from_work_unit] OK");
        end else begin
            $display("[difficulty_target_from_work_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== difficulty_target_from_work_unit.f =====
+incdir+rtl
rtl/dtw_pkg.sv
rtl/dtw_if.sv
rtl/difficulty_target_from_work_unit.sv
rtl/dtw_checker.sv
tb/sv/dtw_target_checker.sv
tb/sv/testbench.sv
